### sv/hermite_keyframe_curve_evaluator_assert.svh
// Assertion macros used by the curve evaluator checker.
`ifndef HERMITE_KEYFRAME_CURVE_EVALUATOR_ASSERT_SVH
`define HERMITE_KEYFRAME_CURVE_EVALUATOR_ASSERT_SVH

// Same-cycle implication, sampled on clk and idle during reset.
`define HKCE_ASSERT_IMP(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("hkce implication check failed");

// Next-cycle implication, sampled on clk and idle during reset.
`define HKCE_ASSERT_NXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("hkce next-cycle check failed");

`endif

### sv/hkce_pkg.sv
// Shared constants and types of the keyframe curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
package hkce_pkg;
    localparam int MAX_KEYFRAMES_DEF = 32;
    localparam int INDEX_W = 5;
    localparam int POS_W   = 16;
    localparam int VAL_W   = 24;
    localparam int QRY_W   = 24;
    localparam int CNT_W   = 6;
    localparam int ENTRY_W = POS_W + 2 * VAL_W;
    localparam int S_TDATA_W = 96;
    localparam int M_TDATA_W = 24;
    localparam int M_TUSER_W = 2;
    localparam int W_BITS    = 17;
    localparam logic signed [VAL_W-1:0] VAL_MAX = 24'sh7FFFFF;
    localparam logic signed [VAL_W-1:0] VAL_MIN = 24'sh800000;

    typedef enum logic {
        ACT_WRITE = 1'b0,
        ACT_QUERY = 1'b1
    } action_t;
endpackage
`default_nettype wire

### sv/hkce_ram.sv
// Generic single-write, single-read RAM with registered read data.
`timescale 1ns / 1ps
`default_nettype none
module hkce_ram #(
    parameter int WIDTH = 64,
    parameter int DEPTH = 32
) (
    input  wire logic                     clk,
    input  wire logic                     we,
    input  wire logic [$clog2(DEPTH)-1:0] waddr,
    input  wire logic [WIDTH-1:0]         wdata,
    input  wire logic [$clog2(DEPTH)-1:0] raddr,
    output logic      [WIDTH-1:0]         rdata
);
    logic [WIDTH-1:0] mem [DEPTH];

    always_ff @(posedge clk)
    begin
        if (we)
        begin
            mem[waddr] <= wdata;
        end
        rdata <= mem[raddr];
    end
endmodule
`default_nettype wire

### sv/hkce_div.sv
// Restoring divider producing the 17-bit blend weight floor(d * 2^16 / span).
`timescale 1ns / 1ps
`default_nettype none
module hkce_div (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            start,
    input  wire logic [hkce_pkg::QRY_W-1:0]      dividend,
    input  wire logic [hkce_pkg::QRY_W-1:0]      divisor,
    output logic                                 done,
    output logic      [hkce_pkg::W_BITS-1:0]     quotient
);
    logic [hkce_pkg::QRY_W:0]   rem_reg, rem_next;
    logic [hkce_pkg::QRY_W-1:0] div_reg, div_next;
    logic [hkce_pkg::W_BITS-1:0] quot_reg, quot_next;
    logic [4:0] cnt_reg, cnt_next;
    logic       first_reg, first_next;
    logic       busy_reg, busy_next;
    logic       done_reg, done_next;
    logic [hkce_pkg::QRY_W:0] trial;
    logic       take;

    always_comb
    begin
        // The dividend never exceeds the divisor, so the first step is unshifted.
        trial = first_reg ? rem_reg : {rem_reg[hkce_pkg::QRY_W-1:0], 1'b0};
        take  = trial >= {1'b0, div_reg};
        rem_next   = rem_reg;
        div_next   = div_reg;
        quot_next  = quot_reg;
        cnt_next   = cnt_reg;
        first_next = first_reg;
        busy_next  = busy_reg;
        done_next  = 1'b0;
        if (start)
        begin
            rem_next   = {1'b0, dividend};
            div_next   = divisor;
            cnt_next   = 5'(hkce_pkg::W_BITS);
            first_next = 1'b1;
            busy_next  = 1'b1;
        end
        else if (busy_reg)
        begin
            rem_next   = take ? trial - {1'b0, div_reg} : trial;
            quot_next  = {quot_reg[hkce_pkg::W_BITS-2:0], take};
            first_next = 1'b0;
            cnt_next   = cnt_reg - 5'd1;
            if (cnt_reg == 5'd1)
            begin
                busy_next = 1'b0;
                done_next = 1'b1;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            busy_reg  <= 1'b0;
            done_reg  <= 1'b0;
            cnt_reg   <= '0;
            first_reg <= 1'b0;
        end
        else
        begin
            busy_reg  <= busy_next;
            done_reg  <= done_next;
            cnt_reg   <= cnt_next;
            first_reg <= first_next;
        end
    end

    always_ff @(posedge clk)
    begin
        rem_reg  <= rem_next;
        div_reg  <= div_next;
        quot_reg <= quot_next;
    end

    assign done     = done_reg;
    assign quotient = quot_reg;
endmodule
`default_nettype wire

### sv/hermite_keyframe_curve_evaluator.sv
// A write beat is taken while the block is idle. A query on an empty table goes straight
// to the result; with one key it reads that key; otherwise it scans the table and, unless
// the left and right frames coincide, runs the divider, the shared-multiplier steps and
// rounding. A stalled output holds the block until the result is taken.
// One item is worked on at a time; the result sits in an output register.
// rst_n clears the key count and all control state; table contents are kept.
`timescale 1ns / 1ps
`default_nettype none
module hermite_keyframe_curve_evaluator #(
    parameter int MAX_KEYFRAMES = hkce_pkg::MAX_KEYFRAMES_DEF
) (
    input  wire logic                              clk,
    input  wire logic                              rst_n,
    input  wire logic                              cfg_we,
    input  wire logic [hkce_pkg::CNT_W-1:0]        cfg_wdata,
    input  wire logic                              s_axis_tvalid,
    output logic                                   s_axis_tready,
    // entry_index[4:0], entry_frame[20:5], entry_value[44:21],
    // entry_slope[68:45], query_frame[92:69], zero fill [95:93]
    input  wire logic [hkce_pkg::S_TDATA_W-1:0]    s_axis_tdata,
    // action[0]
    input  wire logic                              s_axis_tuser,
    output logic                                   m_axis_tvalid,
    input  wire logic                              m_axis_tready,
    // curve_value[23:0]
    output logic      [hkce_pkg::M_TDATA_W-1:0]    m_axis_tdata,
    // saturated[0], table_empty[1]
    output logic      [hkce_pkg::M_TUSER_W-1:0]    m_axis_tuser
);
    localparam int AW = (MAX_KEYFRAMES > 1) ? $clog2(MAX_KEYFRAMES) : 1;
    localparam int NW = $clog2(MAX_KEYFRAMES + 1);
    localparam int EW = hkce_pkg::ENTRY_W;
    localparam int VW = hkce_pkg::VAL_W;

    typedef enum logic [4:0] {
        S_IDLE, S_ONE, S_RINIT, S_SCAN, S_SPAN, S_DIV, S_WW, S_NEG, S_T1,
        S_DA, S_M0, S_M1, S_B, S_BL, S_BH, S_FIN, S_RND, S_EMIT
    } state_t;

    state_t state_reg, state_next;
    logic [hkce_pkg::CNT_W-1:0] count_reg, count_next;
    logic [AW-1:0] idx_reg, idx_next, last_reg, last_next;
    logic [hkce_pkg::QRY_W-1:0] q_reg, q_next;
    logic [EW-1:0] left_reg, left_next, right_reg, right_next;
    logic [hkce_pkg::QRY_W-1:0] d_reg, d_next;
    logic [hkce_pkg::W_BITS-1:0] w_reg, w_next;
    logic signed [52:0] prod_reg, prod_next;
    logic signed [63:0] acc_reg, acc_next;
    logic signed [25:0] a_reg, a_next;
    logic signed [43:0] bsum_reg, bsum_next;
    logic signed [33:0] b_reg, b_next;
    logic signed [VW-1:0] res_val_reg, res_val_next;
    logic res_sat_reg, res_sat_next, res_emp_reg, res_emp_next;
    logic m_valid_reg, m_valid_next;
    logic [VW-1:0] m_data_reg, m_data_next;
    logic [1:0] m_user_reg, m_user_next;

    logic ram_we;
    logic [AW-1:0] ram_waddr, ram_raddr;
    logic [EW-1:0] ram_wdata, ram_rdata;
    logic div_start, div_done;
    logic [hkce_pkg::W_BITS-1:0] div_q;
    logic [hkce_pkg::QRY_W-1:0] span_c;

    logic accept;
    logic [NW-1:0] n_c;
    logic [31:0] cnt_ext;
    logic [hkce_pkg::POS_W-1:0] rd_pos, pos_l, pos_r;
    logic [hkce_pkg::QRY_W-1:0] qpos_l, dd;
    logic signed [33:0] mul_a;
    logic signed [18:0] mul_b;
    logic signed [17:0] wm1;
    logic [17:0] cpoly;
    logic [49:0] negr;
    logic signed [17:0] poly;
    logic signed [VW:0] ydiff;
    logic signed [52:0] ars;
    logic signed [44:0] bs;
    logic signed [63:0] rs;
    logic signed [47:0] r48;
    logic out_free;

    hkce_ram #(.WIDTH(EW), .DEPTH(MAX_KEYFRAMES)) u_ram (
        .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
        .raddr(ram_raddr), .rdata(ram_rdata)
    );

    hkce_div u_div (
        .clk(clk), .rst_n(rst_n), .start(div_start), .dividend(d_next),
        .divisor(span_c), .done(div_done), .quotient(div_q)
    );

    assign s_axis_tready = (state_reg == S_IDLE);
    assign accept = s_axis_tvalid && s_axis_tready;
    assign out_free = !m_valid_reg || m_axis_tready;

    assign ram_waddr = AW'(s_axis_tdata[4:0]);
    assign ram_wdata = {s_axis_tdata[68:45], s_axis_tdata[44:21], s_axis_tdata[20:5]};
    assign ram_we = accept && (s_axis_tuser == hkce_pkg::ACT_WRITE)
                    && ({27'd0, s_axis_tdata[4:0]} < 32'(MAX_KEYFRAMES));

    assign cnt_ext = {26'd0, count_reg};
    assign n_c = (cnt_ext > 32'(MAX_KEYFRAMES)) ? NW'(MAX_KEYFRAMES) : NW'(cnt_ext);

    assign rd_pos = ram_rdata[15:0];
    assign pos_l  = left_reg[15:0];
    assign pos_r  = right_reg[15:0];
    assign qpos_l = {pos_l, 8'd0};
    assign span_c = {pos_r - pos_l, 8'd0};
    assign dd     = q_reg - qpos_l;

    assign wm1   = $signed({1'b0, w_reg}) - 18'sh10000;
    assign cpoly = 18'h30000 - {w_reg, 1'b0};
    assign negr  = {1'b0, prod_reg[48:0]} + 50'h80000000;
    assign poly  = -$signed({1'b0, negr[48:32]});
    assign ydiff = $signed({left_reg[39], left_reg[39:16]})
                   - $signed({right_reg[39], right_reg[39:16]});
    assign ars   = prod_reg + 53'sd32768;
    assign bs    = 45'(bsum_reg) + 45'(prod_reg[43:0]) + 45'sd128;
    assign rs    = acc_reg + 64'sd32768;
    assign r48   = rs[63:16];

    always_comb
    begin
        mul_a = '0;
        mul_b = '0;
        unique case (state_reg)
            S_WW:
            begin
                mul_a = 34'($signed({1'b0, w_reg}));
                mul_b = 19'($signed({1'b0, w_reg}));
            end
            S_NEG:
            begin
                mul_a = $signed({1'b0, prod_reg[32:0]});
                mul_b = $signed({1'b0, cpoly});
            end
            S_T1:
            begin
                mul_a = 34'(ydiff);
                mul_b = 19'(poly);
            end
            S_DA:
            begin
                mul_a = 34'($signed({1'b0, d_reg}));
                mul_b = 19'(wm1);
            end
            S_M0:
            begin
                mul_a = 34'($signed(left_reg[63:40]));
                mul_b = 19'(wm1);
            end
            S_M1:
            begin
                mul_a = 34'($signed(right_reg[63:40]));
                mul_b = 19'($signed({1'b0, w_reg}));
            end
            S_BL:
            begin
                mul_a = 34'(a_reg);
                mul_b = $signed({2'b00, b_reg[16:0]});
            end
            S_BH:
            begin
                mul_a = 34'(a_reg);
                mul_b = 19'($signed(b_reg[33:17]));
            end
            default:
            begin
                mul_a = '0;
                mul_b = '0;
            end
        endcase
        prod_next = 53'(mul_a) * 53'(mul_b);
    end

    always_comb
    begin
        state_next   = state_reg;
        count_next   = cfg_we ? cfg_wdata : count_reg;
        idx_next     = idx_reg;
        last_next    = last_reg;
        q_next       = q_reg;
        left_next    = left_reg;
        right_next   = right_reg;
        d_next       = d_reg;
        w_next       = w_reg;
        acc_next     = acc_reg;
        a_next       = a_reg;
        bsum_next    = bsum_reg;
        b_next       = b_reg;
        res_val_next = res_val_reg;
        res_sat_next = res_sat_reg;
        res_emp_next = res_emp_reg;
        m_valid_next = m_valid_reg && !m_axis_tready;
        m_data_next  = m_data_reg;
        m_user_next  = m_user_reg;
        ram_raddr    = '0;
        div_start    = 1'b0;
        unique case (state_reg)
            S_IDLE:
            begin
                if (accept && (s_axis_tuser == hkce_pkg::ACT_QUERY))
                begin
                    q_next       = s_axis_tdata[92:69];
                    res_sat_next = 1'b0;
                    res_emp_next = 1'b0;
                    last_next    = AW'(n_c - NW'(1));
                    if (n_c == '0)
                    begin
                        res_val_next = '0;
                        res_emp_next = 1'b1;
                        state_next   = S_EMIT;
                    end
                    else if (n_c == NW'(1))
                    begin
                        ram_raddr  = '0;
                        state_next = S_ONE;
                    end
                    else
                    begin
                        ram_raddr  = AW'(n_c - NW'(1));
                        state_next = S_RINIT;
                    end
                end
            end
            S_ONE:
            begin
                res_val_next = $signed(ram_rdata[39:16]);
                state_next   = S_EMIT;
            end
            S_RINIT:
            begin
                right_next = ram_rdata;
                idx_next   = '0;
                ram_raddr  = '0;
                state_next = S_SCAN;
            end
            S_SCAN:
            begin
                // Left is the last key at or before the query; right is the
                // earliest-framed key at or after it, defaulting to the last one.
                if (({rd_pos, 8'd0} <= q_reg) || (idx_reg == '0))
                begin
                    left_next = ram_rdata;
                end
                if (({rd_pos, 8'd0} >= q_reg) && (rd_pos < pos_r))
                begin
                    right_next = ram_rdata;
                end
                ram_raddr = idx_reg + AW'(1);
                idx_next  = idx_reg + AW'(1);
                if (idx_reg == last_reg)
                begin
                    state_next = S_SPAN;
                end
            end
            S_SPAN:
            begin
                if (pos_r <= pos_l)
                begin
                    res_val_next = $signed(left_reg[39:16]);
                    state_next   = S_EMIT;
                end
                else
                begin
                    if (q_reg < qpos_l)
                    begin
                        d_next = '0;
                    end
                    else if (dd > span_c)
                    begin
                        d_next = span_c;
                    end
                    else
                    begin
                        d_next = dd;
                    end
                    div_start  = 1'b1;
                    state_next = S_DIV;
                end
            end
            S_DIV:
            begin
                if (div_done)
                begin
                    w_next     = div_q;
                    state_next = S_WW;
                end
            end
            S_WW:  state_next = S_NEG;
            S_NEG: state_next = S_T1;
            S_T1:  state_next = S_DA;
            S_DA:
            begin
                acc_next   = (64'($signed(left_reg[39:16])) <<< 16) + 64'(prod_reg);
                state_next = S_M0;
            end
            S_M0:
            begin
                a_next     = ars[41:16];
                state_next = S_M1;
            end
            S_M1:
            begin
                bsum_next  = prod_reg[43:0];
                state_next = S_B;
            end
            S_B:
            begin
                b_next     = bs[41:8];
                state_next = S_BL;
            end
            S_BL:  state_next = S_BH;
            S_BH:
            begin
                acc_next   = acc_reg + 64'(prod_reg);
                state_next = S_FIN;
            end
            S_FIN:
            begin
                acc_next   = acc_reg + (64'(prod_reg) <<< 17);
                state_next = S_RND;
            end
            S_RND:
            begin
                if (r48 > 48'(hkce_pkg::VAL_MAX))
                begin
                    res_val_next = hkce_pkg::VAL_MAX;
                    res_sat_next = 1'b1;
                end
                else if (r48 < 48'(hkce_pkg::VAL_MIN))
                begin
                    res_val_next = hkce_pkg::VAL_MIN;
                    res_sat_next = 1'b1;
                end
                else
                begin
                    res_val_next = r48[VW-1:0];
                end
                state_next = S_EMIT;
            end
            S_EMIT:
            begin
                if (out_free)
                begin
                    m_valid_next = 1'b1;
                    m_data_next  = res_val_reg;
                    m_user_next  = {res_emp_reg, res_sat_reg};
                    state_next   = S_IDLE;
                end
            end
            default: state_next = S_IDLE;
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg   <= S_IDLE;
            count_reg   <= '0;
            m_valid_reg <= 1'b0;
            m_data_reg  <= '0;
            m_user_reg  <= '0;
        end
        else
        begin
            state_reg   <= state_next;
            count_reg   <= count_next;
            m_valid_reg <= m_valid_next;
            m_data_reg  <= m_data_next;
            m_user_reg  <= m_user_next;
        end
    end

    always_ff @(posedge clk)
    begin
        idx_reg     <= idx_next;
        last_reg    <= last_next;
        q_reg       <= q_next;
        left_reg    <= left_next;
        right_reg   <= right_next;
        d_reg       <= d_next;
        w_reg       <= w_next;
        prod_reg    <= prod_next;
        acc_reg     <= acc_next;
        a_reg       <= a_next;
        bsum_reg    <= bsum_next;
        b_reg       <= b_next;
        res_val_reg <= res_val_next;
        res_sat_reg <= res_sat_next;
        res_emp_reg <= res_emp_next;
    end

    assign m_axis_tvalid = m_valid_reg;
    assign m_axis_tdata  = m_data_reg;
    assign m_axis_tuser  = m_user_reg;
endmodule
`default_nettype wire

### sv/hkce_checker.sv
// Port-level checker for the keyframe curve evaluator and its bind.
`timescale 1ns / 1ps
`default_nettype none
`include "hermite_keyframe_curve_evaluator_assert.svh"
module hkce_checker (
    input wire logic                           clk,
    input wire logic                           rst_n,
    input wire logic                           s_axis_tvalid,
    input wire logic                           s_axis_tready,
    input wire logic                           s_axis_tuser,
    input wire logic                           m_axis_tvalid,
    input wire logic                           m_axis_tready,
    input wire logic [hkce_pkg::M_TDATA_W-1:0] m_axis_tdata,
    input wire logic [hkce_pkg::M_TUSER_W-1:0] m_axis_tuser
);
    logic out_stall;
    logic out_empty;
    logic out_sat;
    logic out_zero;
    logic out_at_rail;
    logic in_query;

    assign out_stall   = m_axis_tvalid && !m_axis_tready;
    assign out_empty   = m_axis_tvalid && m_axis_tuser[1];
    assign out_sat     = m_axis_tvalid && m_axis_tuser[0];
    assign out_zero    = (m_axis_tdata == '0) && !m_axis_tuser[0];
    assign out_at_rail = (m_axis_tdata == hkce_pkg::VAL_MAX)
                         || (m_axis_tdata == hkce_pkg::VAL_MIN);
    assign in_query    = s_axis_tvalid && s_axis_tready
                         && (s_axis_tuser == hkce_pkg::ACT_QUERY);

    // A stalled result beat holds.
    `HKCE_ASSERT_NXT(a_out_hold, out_stall, m_axis_tvalid && $stable(m_axis_tdata))
    // An empty table reports zero and no clamping.
    `HKCE_ASSERT_IMP(a_empty_zero, out_empty, out_zero)
    // A clamped value sits at one end of the range.
    `HKCE_ASSERT_IMP(a_sat_rail, out_sat, out_at_rail)
    // A query beat occupies the block, so the next cycle takes no input.
    `HKCE_ASSERT_NXT(a_query_busy, in_query, !s_axis_tready)
endmodule

bind hermite_keyframe_curve_evaluator hkce_checker u_hkce_checker (
    .clk(clk), .rst_n(rst_n),
    .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
    .s_axis_tuser(s_axis_tuser),
    .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
    .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
);
`default_nettype wire

### sim/tb_top.sv
// Self-checking testbench of the Hermite keyframe curve evaluator.
`timescale 1ns / 1ps
`default_nettype none
module tb_top;
    typedef struct packed {
        logic [hkce_pkg::VAL_W-1:0] value;
        logic                       sat;
        logic                       empty;
    } curve_res_t;

    typedef struct {
        bit                  is_cfg;
        hkce_pkg::action_t   act;
        logic [4:0]          idx;
        logic [15:0]         frame;
        logic [23:0]         value;
        logic [23:0]         slope;
        logic [23:0]         query;
        bit                  typed;
        curve_res_t          res;
    } stim_row_t;

    localparam int SETTLE_CYCLES = 80;
    localparam int WATCHDOG_LIMIT = 3000;
    localparam int ITEM_TARGET = 1450;

    logic clk;
    logic rst_n;
    logic cfg_we;
    logic [hkce_pkg::CNT_W-1:0] cfg_wdata;
    logic s_axis_tvalid;
    logic s_axis_tready;
    logic [hkce_pkg::S_TDATA_W-1:0] s_axis_tdata;
    logic s_axis_tuser;
    logic m_axis_tvalid;
    logic m_axis_tready;
    logic [hkce_pkg::M_TDATA_W-1:0] m_axis_tdata;
    logic [hkce_pkg::M_TUSER_W-1:0] m_axis_tuser;

    hermite_keyframe_curve_evaluator uut (
        .clk(clk), .rst_n(rst_n),
        .cfg_we(cfg_we), .cfg_wdata(cfg_wdata),
        .s_axis_tvalid(s_axis_tvalid), .s_axis_tready(s_axis_tready),
        .s_axis_tdata(s_axis_tdata), .s_axis_tuser(s_axis_tuser),
        .m_axis_tvalid(m_axis_tvalid), .m_axis_tready(m_axis_tready),
        .m_axis_tdata(m_axis_tdata), .m_axis_tuser(m_axis_tuser)
    );

    // Shadow copy of the key table and count.
    logic [15:0] key_pos [32];
    logic [23:0] key_val [32];
    logic [23:0] key_slp [32];
    bit          key_written [32];
    int unsigned key_count;

    curve_res_t  pending_curves [$];
    bit          typed_on;
    curve_res_t  typed_res;
    bit          quiet;
    int          errors;
    int          items_sent;
    int          results_seen;
    int          sat_seen;
    int          empty_seen;
    int          idle_cycles;
    int          out_stall;

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    function automatic longint sx24(logic [23:0] x);
        return longint'(signed'(x));
    endfunction

    function automatic longint rnd_shift(longint x, int s);
        return (x + (64'sd1 <<< (s - 1))) >>> s;
    endfunction

    function automatic curve_res_t eval_curve(logic [23:0] q);
        curve_res_t r;
        int n;
        int lft;
        int rgt;
        longint span, d, w, neg, poly, t1, a, b, t2, sum, y0, y1, m0, m1, v;
        n = (key_count > 32) ? 32 : key_count;
        r = '0;
        if (n == 0)
        begin
            r.empty = 1'b1;
            return r;
        end
        if (n == 1)
        begin
            r.value = key_val[0];
            return r;
        end
        lft = 0;
        rgt = n - 1;
        for (int i = 0; i < n; i++)
        begin
            if ({key_pos[i], 8'h00} <= q) lft = i;
            if ({key_pos[i], 8'h00} >= q && key_pos[i] < key_pos[rgt]) rgt = i;
        end
        span = (longint'(key_pos[rgt]) - longint'(key_pos[lft])) * 256;
        if (span <= 0)
        begin
            r.value = key_val[lft];
            return r;
        end
        d = longint'(q) - longint'(key_pos[lft]) * 256;
        if (d < 0) d = 0;
        if (d > span) d = span;
        w = (d <<< 16) / span;
        y0 = sx24(key_val[lft]);
        y1 = sx24(key_val[rgt]);
        m0 = sx24(key_slp[lft]);
        m1 = sx24(key_slp[rgt]);
        neg = (3 * 65536 - 2 * w) * w * w;
        poly = -((neg + (64'sd1 <<< 31)) >>> 32);
        t1 = (y0 - y1) * poly;
        a = rnd_shift(d * (w - 65536), 16);
        b = rnd_shift(m0 * (w - 65536) + m1 * w, 8);
        t2 = a * b;
        sum = y0 * 65536 + t1 + t2;
        v = rnd_shift(sum, 16);
        if (v > 8388607)
        begin
            r.value = hkce_pkg::VAL_MAX;
            r.sat = 1'b1;
        end
        else if (v < -8388608)
        begin
            r.value = hkce_pkg::VAL_MIN;
            r.sat = 1'b1;
        end
        else
        begin
            r.value = v[23:0];
        end
        return r;
    endfunction

    // Input side: update the shadow table or queue the expected curve point.
    always @(posedge clk)
    begin
        if (rst_n && s_axis_tvalid && s_axis_tready)
        begin
            if (s_axis_tuser == hkce_pkg::ACT_WRITE)
            begin
                key_pos[s_axis_tdata[4:0]] = s_axis_tdata[20:5];
                key_val[s_axis_tdata[4:0]] = s_axis_tdata[44:21];
                key_slp[s_axis_tdata[4:0]] = s_axis_tdata[68:45];
            end
            else if (typed_on)
            begin
                pending_curves = {pending_curves, typed_res};
            end
            else
            begin
                pending_curves = {pending_curves, eval_curve(s_axis_tdata[92:69])};
            end
        end
    end

    // Output side: compare every result beat with the oldest expectation.
    always @(posedge clk)
    begin
        curve_res_t exp_r;
        if (rst_n && m_axis_tvalid && m_axis_tready)
        begin
            results_seen++;
            if (pending_curves.size() == 0)
            begin
                errors++;
                $display("%0t: unexpected result beat value=%h user=%b",
                         $time, m_axis_tdata, m_axis_tuser);
            end
            else
            begin
                exp_r = pending_curves.pop_front();
                if (exp_r.sat) sat_seen++;
                if (exp_r.empty) empty_seen++;
                if (m_axis_tdata !== exp_r.value)
                begin
                    errors++;
                    $display("%0t: curve_value expected %h actual %h",
                             $time, exp_r.value, m_axis_tdata);
                end
                if (m_axis_tuser[0] !== exp_r.sat)
                begin
                    errors++;
                    $display("%0t: saturated expected %b actual %b",
                             $time, exp_r.sat, m_axis_tuser[0]);
                end
                if (m_axis_tuser[1] !== exp_r.empty)
                begin
                    errors++;
                    $display("%0t: table_empty expected %b actual %b",
                             $time, exp_r.empty, m_axis_tuser[1]);
                end
            end
        end
    end

    // Receiver stalls come in short bursts.
    always @(posedge clk)
    begin
        if (!rst_n || quiet)
        begin
            m_axis_tready <= 1'b1;
            out_stall <= 0;
        end
        else if (out_stall > 0)
        begin
            m_axis_tready <= 1'b0;
            out_stall <= out_stall - 1;
        end
        else if ($urandom_range(0, 5) == 0)
        begin
            m_axis_tready <= 1'b0;
            out_stall <= $urandom_range(0, 4);
        end
        else
        begin
            m_axis_tready <= 1'b1;
        end
    end

    always @(posedge clk)
    begin
        if (!rst_n || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready)
            || cfg_we)
            idle_cycles <= 0;
        else
            idle_cycles <= idle_cycles + 1;
        if (idle_cycles >= WATCHDOG_LIMIT)
        begin
            $display("%0t: watchdog expired, %0d results pending",
                     $time, pending_curves.size());
            $display("hermite_keyframe_curve_evaluator: mismatch");
            $finish;
        end
    end

    task automatic send_beat(hkce_pkg::action_t act, logic [4:0] idx, logic [15:0] frame,
                             logic [23:0] value, logic [23:0] slope, logic [23:0] query);
        if (!quiet && $urandom_range(0, 4) == 0)
        begin
            s_axis_tvalid <= 1'b0;
            repeat ($urandom_range(1, 5)) @(posedge clk);
        end
        s_axis_tvalid <= 1'b1;
        s_axis_tuser <= act;
        s_axis_tdata <= {3'b000, query, slope, value, frame, idx};
        @(posedge clk);
        while (!s_axis_tready) @(posedge clk);
        items_sent++;
        if (act == hkce_pkg::ACT_WRITE) key_written[idx] = 1'b1;
    endtask

    task automatic settle();
        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_curves.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
    endtask

    task automatic set_count(int unsigned n);
        settle();
        cfg_we <= 1'b1;
        cfg_wdata <= n[hkce_pkg::CNT_W-1:0];
        @(posedge clk);
        cfg_we <= 1'b0;
        key_count = n;
    endtask

    function automatic logic [23:0] rand_level();
        case ($urandom_range(0, 3))
            0: return 24'($urandom_range(0, 24'hFFFFFF));
            1: return 24'($signed($urandom_range(0, 2 * 65536)) - 65536);
            default: return 24'($signed($urandom_range(0, 16 * 65536)) - 8 * 65536);
        endcase
    endfunction

    function automatic int unsigned max_safe_count();
        int unsigned n;
        n = 0;
        while (n < 32 && key_written[n]) n++;
        return (n == 32) ? 63 : n;
    endfunction

    stim_row_t dir_rows [$];

    task automatic add_row(bit is_cfg, hkce_pkg::action_t act, logic [4:0] idx,
                           logic [15:0] frame, logic [23:0] value, logic [23:0] slope,
                           logic [23:0] query, bit typed, curve_res_t res);
        stim_row_t r;
        r.is_cfg = is_cfg; r.act = act; r.idx = idx; r.frame = frame;
        r.value = value; r.slope = slope; r.query = query; r.typed = typed; r.res = res;
        dir_rows = {dir_rows, r};
    endtask

    initial
    begin
        int unsigned n, eff, span_max, fr, qlo, qhi, batch;
        rst_n = 1'b0;
        cfg_we = 1'b0;
        cfg_wdata = '0;
        s_axis_tvalid = 1'b0;
        s_axis_tdata = '0;
        s_axis_tuser = hkce_pkg::ACT_WRITE;
        typed_on = 1'b0;
        quiet = 1'b0;
        items_sent = 0;
        key_count = 0;
        for (int i = 0; i < 32; i++)
        begin
            key_written[i] = 1'b0;
        end
        repeat (12) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // Directed rows: empty table, extremes, single key, equal keys,
        // right key ahead of left, queries outside the keys.
        add_row(1, hkce_pkg::ACT_WRITE, 0, 0, 0, 0, 0, 0, '0);
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'h000000, 1,
                '{24'h000000, 1'b0, 1'b1});
        add_row(0, hkce_pkg::ACT_QUERY, 31, 16'hFFFF, 24'hFFFFFF, 24'hFFFFFF, 24'hFFFFFF, 1,
                '{24'h000000, 1'b0, 1'b1});
        add_row(0, hkce_pkg::ACT_WRITE, 0, 16'h0000, 24'h7FFFFF, 24'h7FFFFF, 0, 0, '0);
        add_row(0, hkce_pkg::ACT_WRITE, 1, 16'h0001, 24'h800000, 24'h800000, 0, 0, '0);
        add_row(0, hkce_pkg::ACT_WRITE, 2, 16'hFFFF, 24'h000000, 24'h000000, 0, 0, '0);
        add_row(0, hkce_pkg::ACT_WRITE, 3, 16'hFFFF, 24'h000001, 24'hFFFFFF, 0, 0, '0);
        add_row(0, hkce_pkg::ACT_WRITE, 31, 16'h8000, 24'h010000, 24'h000100, 0, 0, '0);
        add_row(1, hkce_pkg::ACT_WRITE, 1, 0, 0, 0, 0, 0, '0);
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'h012345, 1,
                '{24'h7FFFFF, 1'b0, 1'b0});
        add_row(1, hkce_pkg::ACT_WRITE, 2, 0, 0, 0, 0, 0, '0);
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'h000080, 0, '0);
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'h000040, 0, '0);
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'h000000, 0, '0);
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'hFFFFFF, 1,
                '{24'h800000, 1'b0, 1'b0});
        add_row(1, hkce_pkg::ACT_WRITE, 4, 0, 0, 0, 0, 0, '0);
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'hFFFF00, 1,
                '{24'h000001, 1'b0, 1'b0});
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'h000100, 1,
                '{24'h800000, 1'b0, 1'b0});
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'h008000, 0, '0);
        add_row(0, hkce_pkg::ACT_QUERY, 0, 0, 0, 0, 24'h000180, 0, '0);

        foreach (dir_rows[k])
        begin
            if (dir_rows[k].is_cfg)
            begin
                set_count(32'(dir_rows[k].idx));
            end
            else
            begin
                typed_on = dir_rows[k].typed;
                typed_res = dir_rows[k].res;
                send_beat(dir_rows[k].act, dir_rows[k].idx, dir_rows[k].frame,
                          dir_rows[k].value, dir_rows[k].slope, dir_rows[k].query);
                s_axis_tvalid <= 1'b0;
                @(posedge clk);
                typed_on = 1'b0;
            end
        end

        // Random phases: mostly ascending tables with random content.
        while (items_sent < ITEM_TARGET)
        begin
            if (items_sent > ITEM_TARGET - 150) quiet = 1'b1;
            case ($urandom_range(0, 7))
                0: n = 0;
                1: n = 1;
                2: n = 2;
                3: n = 32;
                4: n = $urandom_range(33, 63);
                default: n = $urandom_range(2, 8);
            endcase
            eff = (n > 32) ? 32 : n;
            if ($urandom_range(0, 3) != 0 || max_safe_count() < n)
            begin
                case ($urandom_range(0, 2))
                    0: span_max = 1;
                    1: span_max = 16;
                    default: span_max = 2000;
                endcase
                fr = $urandom_range(0, 65535 - eff * span_max);
                for (int i = 0; i < eff; i++)
                begin
                    send_beat(hkce_pkg::ACT_WRITE, 5'(i), 16'(fr), rand_level(), rand_level(),
                              24'($urandom()));
                    fr = fr + $urandom_range(0, span_max);
                    if ($urandom_range(0, 9) == 0) fr = fr + 1;
                    if (fr > 65535) fr = 65535;
                end
            end
            set_count(n);
            qlo = (eff > 0) ? key_pos[0] * 256 : 0;
            qhi = (eff > 0) ? key_pos[eff - 1] * 256 : 24'hFFFFFF;
            if (qhi < qlo) qhi = qlo;
            batch = $urandom_range(10, 30);
            for (int j = 0; j < batch; j++)
            begin
                if ($urandom_range(0, 9) == 0)
                begin
                    send_beat(hkce_pkg::ACT_WRITE, 5'($urandom_range(0, 31)), 16'($urandom()),
                              24'($urandom()), 24'($urandom()), 24'($urandom()));
                end
                else if ($urandom_range(0, 7) == 0)
                begin
                    send_beat(hkce_pkg::ACT_QUERY, 5'($urandom()), 16'($urandom()),
                              24'($urandom()), 24'($urandom()),
                              24'($urandom_range(0, 24'hFFFFFF)));
                end
                else
                begin
                    send_beat(hkce_pkg::ACT_QUERY, 5'($urandom()), 16'($urandom()),
                              24'($urandom()), 24'($urandom()),
                              24'((qlo > 512 ? qlo - 512 : 0)
                                  + $urandom_range(0, qhi - qlo + 1024)));
                end
            end
        end

        s_axis_tvalid <= 1'b0;
        @(posedge clk);
        while (pending_curves.size() != 0) @(posedge clk);
        repeat (SETTLE_CYCLES) @(posedge clk);
        $display("Covered %0d input beats and %0d curve results (%0d saturated, %0d empty).",
                 items_sent, results_seen, sat_seen, empty_seen);
        if (errors == 0)
        begin
            $display("hermite_keyframe_curve_evaluator: match");
        end
        else
        begin
            $display("hermite_keyframe_curve_evaluator: mismatch");
        end
        $finish;
    end
endmodule
`default_nettype wire
